FILE: rtl/binomial_mod_prime_assert.svh
// ----------------------------------------------------------------------------
// binomial_mod_prime_assert.svh
// Assertion macros shared by the binomial-mod-prime RTL.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_MOD_PRIME_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Types, constants and codes shared by the binomial-mod-prime modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  localparam int ARG_BITS_DEF = 20;
  localparam int RES_W        = 30;

  localparam logic [63:0]      PRIME_FULL = 64'd998244353;
  localparam logic [RES_W-1:0] PRIME_MOD  = PRIME_FULL[RES_W-1:0];
  localparam logic [RES_W-1:0] EXP_INV    = PRIME_MOD - 30'd2;

  // Barrett reciprocal floor(2^60 / prime), fits in 31 bits
  localparam logic [63:0] MU_FULL    = (64'd1 << 60) / PRIME_FULL;
  localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

  // Multiplier operation: picks operands and the write-back target
  typedef enum logic [2:0] {
    OP_FACT,
    OP_BOT,
    OP_PMUL,
    OP_PSQ,
    OP_FINAL
  } mop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FACT_ISSUE,
    ST_FACT_WAIT,
    ST_BOT_ISSUE,
    ST_BOT_WAIT,
    ST_PMUL_ISSUE,
    ST_PMUL_WAIT,
    ST_PSQ_ISSUE,
    ST_PSQ_WAIT,
    ST_FIN_ISSUE,
    ST_FIN_WAIT,
    ST_DONE
  } bmp_state_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic wr;
    logic zero_res;
    mop_t op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic k_gt_n;
    logic n_zero;
    logic fact_last;
    logic exp_bit;
    logic exp_end;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/bmp_modmul.sv
// ----------------------------------------------------------------------------
// bmp_modmul
// Three-stage modular multiplier, a * b mod prime, Barrett reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_modmul
  import bmp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [RES_W-1:0] a,
  input  wire logic [RES_W-1:0] b,
  output logic                  done,
  output logic [RES_W-1:0]      p
);

  logic        v1, v2, v3;
  logic [59:0] x1;
  logic [61:0] q2;
  logic [31:0] x2;
  logic [31:0] r3;
  logic [30:0] q3;
  logic [60:0] qp;
  logic [31:0] r1, r2;
  logic [31:0] prime32;

  assign prime32 = {2'b00, PRIME_MOD};
  assign q3      = q2[61:31];
  assign qp      = {30'd0, q3} * {31'd0, PRIME_MOD};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // full product, then quotient estimate, then remainder below 3 * prime
  always_ff @(posedge clk) begin
    x1 <= {30'd0, a} * {30'd0, b};
    q2 <= {31'd0, x1[59:29]} * {31'd0, BARRETT_MU};
    x2 <= x1[31:0];
    r3 <= x2 - qp[31:0];
  end

  // fold the remainder into range
  assign r1   = (r3 >= prime32) ? r3 - prime32 : r3;
  assign r2   = (r1 >= prime32) ? r1 - prime32 : r1;
  assign p    = r2[RES_W-1:0];
  assign done = v3;

endmodule

`default_nettype wire

FILE: rtl/bmp_datapath.sv
// ----------------------------------------------------------------------------
// bmp_datapath
// Operand registers, operand select and write-back around the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_datapath
  import bmp_pkg::*;
#(
  parameter int ARG_BITS = ARG_BITS_DEF
)(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  input  wire logic [ARG_BITS-1:0] n_value,
  input  wire logic [ARG_BITS-1:0] k_value,
  output sts_t                     sts,
  output logic [RES_W-1:0]         binom_result
);

  logic [ARG_BITS-1:0] n_r, k_r, nk, i;
  logic [RES_W-1:0]    acc, fk, fnk, base, pacc, expo, result;
  logic [RES_W-1:0]    op_a, op_b;
  logic                mul_done;
  logic [RES_W-1:0]    prod;

  // pick operands for the requested product
  always_comb begin
    case (cmd.op)
      OP_FACT: begin
        op_a = acc;
        op_b = RES_W'(i);
      end
      OP_BOT: begin
        op_a = fk;
        op_b = fnk;
      end
      OP_PMUL: begin
        op_a = pacc;
        op_b = base;
      end
      OP_PSQ: begin
        op_a = base;
        op_b = base;
      end
      OP_FINAL: begin
        op_a = acc;
        op_b = pacc;
      end
      default: begin
        op_a = acc;
        op_b = pacc;
      end
    endcase
  end

  bmp_modmul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (op_a),
    .b    (op_b),
    .done (mul_done),
    .p    (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= n_value;
      k_r  <= k_value;
      nk   <= n_value - k_value;
      i    <= ARG_BITS'(1);
      acc  <= RES_W'(1);
      fk   <= RES_W'(1);
      fnk  <= RES_W'(1);
      pacc <= RES_W'(1);
      expo <= EXP_INV;
    end else if (cmd.zero_res) begin
      result <= '0;
    end else if (cmd.wr) begin
      case (cmd.op)
        OP_FACT: begin
          acc <= prod;
          i   <= i + ARG_BITS'(1);
          if (i == k_r) begin
            fk <= prod;
          end
          if (i == nk) begin
            fnk <= prod;
          end
        end
        OP_BOT:  base <= prod;
        OP_PMUL: pacc <= prod;
        OP_PSQ: begin
          base <= prod;
          expo <= expo >> 1;
        end
        OP_FINAL: result <= prod;
        default: ;
      endcase
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.k_gt_n    = (k_r > n_r);
  assign sts.n_zero    = (n_r == '0);
  assign sts.fact_last = (i == n_r);
  assign sts.exp_bit   = expo[0];
  assign sts.exp_end   = (expo[RES_W-1:1] == '0);
  assign binom_result  = result;

endmodule

`default_nettype wire

FILE: rtl/bmp_ctrl.sv
// ----------------------------------------------------------------------------
// bmp_ctrl
// Sequencer: factorial pass, denominator product, Fermat inverse, final product.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_ctrl
  import bmp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      done
);

  bmp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.mul_go   = 1'b0;
    cmd.wr       = 1'b0;
    cmd.zero_res = 1'b0;
    cmd.op       = OP_FACT;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.k_gt_n) begin
          cmd.zero_res = 1'b1;
          state_next   = ST_DONE;
        end else if (sts.n_zero) begin
          state_next = ST_BOT_ISSUE;
        end else begin
          state_next = ST_FACT_ISSUE;
        end
      end
      ST_FACT_ISSUE: begin
        cmd.op     = OP_FACT;
        cmd.mul_go = 1'b1;
        state_next = ST_FACT_WAIT;
      end
      ST_FACT_WAIT: begin
        cmd.op = OP_FACT;
        if (sts.mul_done) begin
          cmd.wr     = 1'b1;
          state_next = sts.fact_last ? ST_BOT_ISSUE : ST_FACT_ISSUE;
        end
      end
      ST_BOT_ISSUE: begin
        cmd.op     = OP_BOT;
        cmd.mul_go = 1'b1;
        state_next = ST_BOT_WAIT;
      end
      ST_BOT_WAIT: begin
        cmd.op = OP_BOT;
        if (sts.mul_done) begin
          cmd.wr     = 1'b1;
          state_next = ST_PMUL_ISSUE;
        end
      end
      ST_PMUL_ISSUE: begin
        cmd.op = OP_PMUL;
        if (sts.exp_bit) begin
          cmd.mul_go = 1'b1;
          state_next = ST_PMUL_WAIT;
        end else begin
          state_next = ST_PSQ_ISSUE;
        end
      end
      ST_PMUL_WAIT: begin
        cmd.op = OP_PMUL;
        if (sts.mul_done) begin
          cmd.wr     = 1'b1;
          state_next = ST_PSQ_ISSUE;
        end
      end
      ST_PSQ_ISSUE: begin
        cmd.op     = OP_PSQ;
        cmd.mul_go = 1'b1;
        state_next = ST_PSQ_WAIT;
      end
      ST_PSQ_WAIT: begin
        cmd.op = OP_PSQ;
        if (sts.mul_done) begin
          cmd.wr     = 1'b1;
          state_next = sts.exp_end ? ST_FIN_ISSUE : ST_PMUL_ISSUE;
        end
      end
      ST_FIN_ISSUE: begin
        cmd.op     = OP_FINAL;
        cmd.mul_go = 1'b1;
        state_next = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        cmd.op = OP_FINAL;
        if (sts.mul_done) begin
          cmd.wr     = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/binomial_mod_prime.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime
// C(n,k) mod 998244353 with one shared three-stage modular multiplier.
// ----------------------------------------------------------------------------
// Each factorial step is an issue state followed by the multiplier's three stages;
//   the Fermat inverse walks the 30-bit exponent (28 of its bits set), squaring for
//   every bit and multiplying for each set bit; k > n goes straight to done.
// Throughput: one word per run; busy stays high until the cycle after done, so a
//   new word is taken only once the previous run has finished.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous) returns the sequencer to idle; no memory to clear.
`default_nettype none

module binomial_mod_prime
  import bmp_pkg::*;
#(
  parameter int ARG_BITS = ARG_BITS_DEF
)(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ARG_BITS-1:0] n_value,
  input  wire logic [ARG_BITS-1:0] k_value,
  output logic                     done,
  output logic [RES_W-1:0]         binom_result
);

  `include "binomial_mod_prime_assert.svh"

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: walk n! capturing k! and (n-k)!, then invert and multiply
  bmp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: operand registers around the shared multiplier
  bmp_datapath #(
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .n_value      (n_value),
    .k_value      (k_value),
    .sts          (sts),
    .binom_result (binom_result)
  );

  // strobe only inside a run
  `BMP_ASSERT_NOW(a_done_busy, done, busy, "done outside a run")
  // an accepted word starts a run
  `BMP_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted word lost")
  // result always reduced
  `BMP_ASSERT_NOW(a_res_range, done, binom_result < PRIME_MOD, "result not reduced")
  // no multiply issued while writing back
  `BMP_ASSERT_NOW(a_go_wr, cmd.mul_go, !cmd.wr, "issue overlaps write-back")

endmodule

`default_nettype wire
